/* sv/eeac_pkg.sv */
// Shared types, constants and register codes of the encoder angle correction block.
package eeac_pkg;

	// Offset table geometry. The table size must be a power of two.
	localparam int TABLE_POINTS = 256;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam int ANGLE_W  = 16;
	localparam int OFFSET_W = 16;
	localparam int ENTRY_W  = 8;
	localparam int PP_W     = 7;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS         = 2'd2;

	// Operation codes of an input transaction.
	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_WRITE   = 1'b1;

	// Millidegrees to angle LSBs: m * 65536 / 360000 = m * 1024 / 5625.
	// The quotient by 5625 uses a reciprocal multiply and one correction step.
	localparam int MAG_W       = 16;
	localparam int LSB_SHIFT   = 10;
	localparam int NUM_W       = MAG_W + LSB_SHIFT;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 32;
	localparam int Q_W         = 13;
	localparam logic [RECIP_W-1:0] RECIP  = 20'd763549;
	localparam logic [Q_W-1:0]     DIV_D  = 13'd5625;

	typedef struct packed {
		logic                is_write;
		logic                wr_en;
		logic [IDX_W-1:0]    wr_idx;
		logic [OFFSET_W-1:0] wr_data;
		logic [IDX_W-1:0]    rd_idx;
		logic [IDX_W-1:0]    rd_nxt;
		logic [ANGLE_W-1:0]  frac;
		logic [ANGLE_W-1:0]  raw;
	} cmd_t;

	typedef struct packed {
		logic               calibration_enable;
		logic [ANGLE_W-1:0] zero_offset;
		logic [PP_W-1:0]    pole_pairs;
	} cfg_t;

endpackage

/* sv/eeac_ram.sv */
// Generic simple dual-port RAM with one write port and two registered read ports.
module eeac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* sv/eeac_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
module eeac_front
	import eeac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [ANGLE_W-1:0]  raw_angle,
	input  logic [ENTRY_W-1:0]  entry_index,
	input  logic [OFFSET_W-1:0] entry_offset,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_pop
);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cmd_in;
	logic              push;

	// The table index is the top bits of the angle, the fraction the bits below.
	always_comb begin
		cmd_in.is_write = (operation == OP_WRITE);
		cmd_in.wr_en    = (32'(entry_index) < TABLE_POINTS);
		cmd_in.wr_idx   = IDX_W'(entry_index);
		cmd_in.wr_data  = entry_offset;
		cmd_in.rd_idx   = raw_angle[ANGLE_W-1 -: IDX_W];
		cmd_in.rd_nxt   = raw_angle[ANGLE_W-1 -: IDX_W] + 1'b1;
		cmd_in.frac     = ANGLE_W'({raw_angle, {IDX_W{1'b0}}});
		cmd_in.raw      = raw_angle;
	end

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (cmd_pop) begin
				head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[tail_q] <= cmd_in;
		end
	end

endmodule

/* sv/eeac_back.sv */
// Back end: table read, interpolation, unit conversion and angle arithmetic pipeline.
module eeac_back
	import eeac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] electrical_angle,
	output logic [ANGLE_W-1:0] corrected_mechanical
);

	logic advance;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic                  out_valid_q;
	logic [ANGLE_W-1:0]    raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6;
	logic [ANGLE_W-1:0]    frac_s1;
	logic [OFFSET_W-1:0]   ram_a, ram_b;
	logic [OFFSET_W-1:0]   a_s2;
	logic signed [33:0]    prod_s2;
	logic                  neg_s3, neg_s4, neg_s5;
	logic [MAG_W-1:0]      mag_s3;
	logic [NUM_W-1:0]      n_s4, n_s5;
	logic [Q_W-1:0]        q_s4, q_s5;
	logic [NUM_W-1:0]      chk_s5;
	logic [OFFSET_W-1:0]   off_s6;
	logic [ANGLE_W-1:0]    mech_s7;
	logic [ANGLE_W-1:0]    mech_q, elec_q;

	logic signed [16:0]    diff_c;
	logic signed [16:0]    frac_c;
	logic signed [33:0]    prod_c;
	logic signed [17:0]    mdeg_c;
	logic [17:0]           mag_c;
	logic [NUM_W-1:0]      num_c;
	logic [NUM_W+RECIP_W-1:0] qprod_c;
	logic [NUM_W-1:0]      rem_c;
	logic [Q_W-1:0]        qfin_c;
	logic [ANGLE_W-1:0]    corr_c;
	logic [ANGLE_W+PP_W-1:0] elec_c;

	// The whole pipeline moves together; it holds only when the output is full and not taken.
	assign advance = !out_valid_q || out_ready;
	assign cmd_pop = advance && cmd_valid;

	eeac_ram #(
		.WIDTH(OFFSET_W),
		.DEPTH(TABLE_POINTS)
	) u_table (
		.clk     (clk),
		.we      (cmd_pop && cmd.is_write && cmd.wr_en),
		.waddr   (cmd.wr_idx),
		.wdata   (cmd.wr_data),
		.re      (advance),
		.raddr_a (cmd.rd_idx),
		.raddr_b (cmd.rd_nxt),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_comb begin
		diff_c  = $signed({ram_b[OFFSET_W-1], ram_b}) - $signed({ram_a[OFFSET_W-1], ram_a});
		frac_c  = $signed({1'b0, frac_s1});
		prod_c  = diff_c * frac_c;
		// Arithmetic shift of the product floors toward minus infinity.
		mdeg_c  = $signed({{2{a_s2[OFFSET_W-1]}}, a_s2}) + $signed(prod_s2[33:16]);
		mag_c   = mdeg_c[17] ? 18'(-mdeg_c) : 18'(mdeg_c);
		num_c   = {mag_s3, {LSB_SHIFT{1'b0}}};
		qprod_c = (NUM_W+RECIP_W)'(num_c) * (NUM_W+RECIP_W)'(RECIP);
		rem_c   = n_s5 - chk_s5;
		qfin_c  = q_s5 + Q_W'(rem_c >= NUM_W'(DIV_D));
		corr_c  = cfg.calibration_enable ? raw_s6 - off_s6 : raw_s6;
		elec_c  = (ANGLE_W+PP_W)'(mech_s7) * (ANGLE_W+PP_W)'(cfg.pole_pairs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd_valid && !cmd.is_write;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			raw_s1  <= cmd.raw;
			frac_s1 <= cmd.frac;

			raw_s2  <= raw_s1;
			a_s2    <= ram_a;
			prod_s2 <= prod_c;

			raw_s3  <= raw_s2;
			neg_s3  <= mdeg_c[17];
			mag_s3  <= mag_c[MAG_W-1:0];

			raw_s4  <= raw_s3;
			neg_s4  <= neg_s3;
			n_s4    <= num_c;
			q_s4    <= qprod_c[RECIP_SHIFT +: Q_W];

			raw_s5  <= raw_s4;
			neg_s5  <= neg_s4;
			n_s5    <= n_s4;
			q_s5    <= q_s4;
			chk_s5  <= NUM_W'(q_s4) * NUM_W'(DIV_D);

			raw_s6  <= raw_s5;
			off_s6  <= neg_s5 ? -OFFSET_W'(qfin_c) : OFFSET_W'(qfin_c);

			mech_s7 <= corr_c - cfg.zero_offset;

			mech_q  <= mech_s7;
			elec_q  <= elec_c[ANGLE_W-1:0];
		end
	end

	assign out_valid            = out_valid_q;
	assign corrected_mechanical = mech_q;
	assign electrical_angle     = elec_q;

endmodule

/* sv/encoder_electrical_angle_correction.sv */
// Top level of the encoder electrical angle correction block with its configuration registers.
//
// The block takes one transaction per clock cycle on the input channel while in_ready is
// high and, once the pipeline is full, delivers one result per cycle on the output channel
// while out_ready is high. A conversion transaction waits in the command queue until the
// back end takes it, then passes seven registered stages of arithmetic (table read,
// interpolation product, offset magnitude, reciprocal multiply, quotient check, signed
// offset, angle subtraction) and the output register, where the electrical angle is
// multiplied by the pole pairs.
// A table write transaction takes one slot of the back end, writes the offset table at
// that moment and returns nothing, so a conversion that follows it already sees the new
// entry. The rate is set by the single write port and dual read port of the offset table,
// which serve one transaction per cycle. A four-entry command queue sits between the
// front end and the back end: the input side keeps accepting while the output is stalled
// until the queue fills, and the whole back end holds only while a finished result waits
// to be taken. Table offsets are in millidegrees and are converted to angle LSBs with
// truncation toward zero; both outputs are 16-bit fractions of a turn. Configuration
// writes are always accepted and must only be issued while no transaction is in flight.
// Table entries never written hold no defined value, so load every entry that a
// conversion can touch before enabling calibration.
module encoder_electrical_angle_correction
	import eeac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [ANGLE_W-1:0]    raw_angle,
	input  logic [ENTRY_W-1:0]    entry_index,
	input  logic [OFFSET_W-1:0]   entry_offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ANGLE_W-1:0]    electrical_angle,
	output logic [ANGLE_W-1:0]    corrected_mechanical
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// Configuration writes complete in the cycle they are presented.
	assign cfg_ready = 1'b1;

	// Writes to an index past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calibration_enable <= 1'b0;
			cfg_q.zero_offset        <= '0;
			cfg_q.pole_pairs         <= PP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CALIBRATION_ENABLE: cfg_q.calibration_enable <= cfg_data[0];
				CFG_ZERO_OFFSET:        cfg_q.zero_offset        <= cfg_data[ANGLE_W-1:0];
				CFG_POLE_PAIRS:         cfg_q.pole_pairs         <= cfg_data[PP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	eeac_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.raw_angle    (raw_angle),
		.entry_index  (entry_index),
		.entry_offset (entry_offset),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	eeac_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.cmd_valid            (cmd_valid),
		.cmd                  (cmd),
		.cmd_pop              (cmd_pop),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.electrical_angle     (electrical_angle),
		.corrected_mechanical (corrected_mechanical)
	);

	// The back end never takes a command from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");

	// The queue only becomes full through an accepted input transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input ready dropped without an accepted transaction");

	// A pole pair write lands in the register used by the output multiplier.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == CFG_POLE_PAIRS |=> cfg_q.pole_pairs == $past(cfg_data[PP_W-1:0]))
		else $error("pole pair register not updated by its write");

endmodule
